### src/efr_pkg.sv
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Byte type and the framing constants used by the escaped frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

    typedef logic [7:0] byte_t;

    // Start-of-frame flag, escape marker and the pattern that an escaped
    // byte is XORed with.
    localparam byte_t FLAG_BYTE   = 8'h7E;
    localparam byte_t ESCAPE_BYTE = 8'h7D;
    localparam byte_t ESCAPE_XOR  = 8'h20;

endpackage

### src/escaped_frame_receiver.sv
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Deframes a byte-stuffed serial stream of the form flag, id, length,
// payload, XOR checksum, and reports each payload byte and a frame verdict.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                 Payload
//  -------  ------------------------  ---------------------------------------
//  input    in_valid / in_stall       line_byte
//  output   out_valid / out_stall     frame_id, frame_length, data_byte,
//                                     byte_index, is_end, checksum_good
//
// One item is accepted per cycle unless the input is stalled. An accepted
// item is held in the input register; once the result register can take a
// value, it updates the framing state and, if it is a payload or checksum
// byte, loads the result register, which drives the output. A stall on the
// output only holds the input side once both the input register and the
// result register are full. Reset returns the receiver to waiting for a
// flag with both registers empty.
//
// Framing: a flag byte restarts the frame from any phase. Inside a frame an
// escape marker makes the following byte be XORed with the escape pattern.
// Bytes outside a frame are dropped. A zero length skips straight to the
// checksum byte. The checksum is the XOR of id, length and all payload
// bytes; the end item carries the received checksum and the verdict.
// ----------------------------------------------------------------------------
module escaped_frame_receiver
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  efr_pkg::byte_t       line_byte,

    output logic                 out_valid,
    input  logic                 out_stall,
    output efr_pkg::byte_t       frame_id,
    output efr_pkg::byte_t       frame_length,
    output efr_pkg::byte_t       data_byte,
    output efr_pkg::byte_t       byte_index,
    output logic                 is_end,
    output logic                 checksum_good
);

    typedef enum logic [2:0]
    {
        PH_WAIT,
        PH_ID,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    // Input register.
    logic            in_valid_reg;
    efr_pkg::byte_t  byte_reg;

    // Framing state.
    phase_t          phase_reg,     phase_next;
    logic            escape_reg,    escape_next;
    efr_pkg::byte_t  id_reg,        id_next;
    efr_pkg::byte_t  length_reg,    length_next;
    efr_pkg::byte_t  count_reg,     count_next;
    efr_pkg::byte_t  xor_reg,       xor_next;

    // Result register.
    logic            out_valid_reg;
    efr_pkg::byte_t  out_id_reg;
    efr_pkg::byte_t  out_length_reg;
    efr_pkg::byte_t  out_data_reg;
    efr_pkg::byte_t  out_index_reg;
    logic            out_end_reg;
    logic            out_good_reg;

    // Per-item decode.
    logic            advance;
    logic            fire;
    logic            emit;
    logic            emit_end;
    logic            emit_good;
    efr_pkg::byte_t  emit_data;
    efr_pkg::byte_t  emit_index;
    efr_pkg::byte_t  plain_byte;

    // The result register can take a new value when empty or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_comb
    begin
        phase_next  = phase_reg;
        escape_next = escape_reg;
        id_next     = id_reg;
        length_next = length_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        emit        = 1'b0;
        emit_end    = 1'b0;
        emit_good   = 1'b0;
        emit_data   = byte_reg;
        emit_index  = count_reg;
        plain_byte  = escape_reg ? (byte_reg ^ efr_pkg::ESCAPE_XOR) : byte_reg;

        if (byte_reg == efr_pkg::FLAG_BYTE)
        begin
            escape_next = 1'b0;
            count_next  = '0;
            phase_next  = PH_ID;
        end
        else if (phase_reg == PH_WAIT)
        begin
            phase_next = PH_WAIT;
        end
        else if (byte_reg == efr_pkg::ESCAPE_BYTE)
        begin
            escape_next = 1'b1;
        end
        else
        begin
            escape_next = 1'b0;
            unique case (phase_reg)
                PH_ID:
                begin
                    id_next    = plain_byte;
                    phase_next = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    length_next = plain_byte;
                    xor_next    = id_reg ^ plain_byte;
                    count_next  = '0;
                    phase_next  = (plain_byte == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    xor_next   = xor_reg ^ plain_byte;
                    emit       = 1'b1;
                    emit_data  = plain_byte;
                    count_next = count_reg + 8'd1;
                    if (count_next == length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    emit       = 1'b1;
                    emit_end   = 1'b1;
                    emit_data  = plain_byte;
                    emit_good  = (plain_byte == xor_reg);
                    phase_next = PH_WAIT;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            byte_reg       <= '0;
            phase_reg      <= PH_WAIT;
            escape_reg     <= 1'b0;
            id_reg         <= '0;
            length_reg     <= '0;
            count_reg      <= '0;
            xor_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_id_reg     <= '0;
            out_length_reg <= '0;
            out_data_reg   <= '0;
            out_index_reg  <= '0;
            out_end_reg    <= 1'b0;
            out_good_reg   <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
                if (in_valid)
                begin
                    byte_reg <= line_byte;
                end
            end

            if (fire)
            begin
                phase_reg  <= phase_next;
                escape_reg <= escape_next;
                id_reg     <= id_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                xor_reg    <= xor_next;
            end

            if (advance)
            begin
                out_valid_reg <= fire && emit;
                if (fire && emit)
                begin
                    out_id_reg     <= id_reg;
                    out_length_reg <= length_reg;
                    out_data_reg   <= emit_data;
                    out_index_reg  <= emit_index;
                    out_end_reg    <= emit_end;
                    out_good_reg   <= emit_good;
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_id      = out_id_reg;
    assign frame_length  = out_length_reg;
    assign data_byte     = out_data_reg;
    assign byte_index    = out_index_reg;
    assign is_end        = out_end_reg;
    assign checksum_good = out_good_reg;

    // A byte processed while waiting for a flag never yields a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_WAIT) |=> !out_valid)
        else $error("result produced outside a frame");

    // Payload results stay below the declared length and carry no good verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_end) |-> (byte_index < frame_length && !checksum_good))
        else $error("payload result index or verdict out of range");

    // The end result reports exactly the declared number of payload bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_end) |-> (byte_index == frame_length))
        else $error("end result count differs from frame length");

    // An escape can only be pending inside a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        escape_reg |-> (phase_reg != PH_WAIT))
        else $error("escape pending outside a frame");

endmodule

### bench/escaped_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// Escaped frame receiver testbench
// Sends a byte-stuffed line stream into the receiver, predicts every payload
// and end-of-frame result in a scoreboard, and checks each result in order.
// ----------------------------------------------------------------------------

// One result as the receiver presents it on its output channel.
typedef struct {
    efr_pkg::byte_t frame_id;
    efr_pkg::byte_t frame_length;
    efr_pkg::byte_t data_byte;
    efr_pkg::byte_t byte_index;
    logic           is_end;
    logic           checksum_good;
} frame_result_t;

typedef enum logic [2:0] {
    RX_WAIT_FLAG,
    RX_ID,
    RX_LENGTH,
    RX_PAYLOAD,
    RX_CHECK_BYTE
} rx_phase_t;

// Tracks the deframing state of the line and holds the results that the
// receiver still owes, oldest first.
class deframe_scoreboard;
    rx_phase_t      phase        = RX_WAIT_FLAG;
    bit             escape_armed = 1'b0;
    efr_pkg::byte_t cur_id       = '0;
    efr_pkg::byte_t cur_length   = '0;
    efr_pkg::byte_t payload_seen = '0;
    efr_pkg::byte_t running_sum  = '0;
    frame_result_t  owed_results[$];
    int unsigned    mismatches   = 0;

    function void owe_result(efr_pkg::byte_t data, bit end_flag, bit good);
        frame_result_t r;
        r.frame_id      = cur_id;
        r.frame_length  = cur_length;
        r.data_byte     = data;
        r.byte_index    = payload_seen;
        r.is_end        = end_flag;
        r.checksum_good = good;
        owed_results.push_back(r);
    endfunction

    // Advances the framing state by one accepted line byte.
    function void note_line_byte(efr_pkg::byte_t raw);
        efr_pkg::byte_t b;
        b = raw;
        if (b == efr_pkg::FLAG_BYTE) begin
            escape_armed = 1'b0;
            payload_seen = '0;
            phase        = RX_ID;
            return;
        end
        if (phase == RX_WAIT_FLAG)
            return;
        if (b == efr_pkg::ESCAPE_BYTE) begin
            escape_armed = 1'b1;
            return;
        end
        if (escape_armed) begin
            b            = b ^ efr_pkg::ESCAPE_XOR;
            escape_armed = 1'b0;
        end
        case (phase)
            RX_ID:
            begin
                cur_id = b;
                phase  = RX_LENGTH;
            end
            RX_LENGTH:
            begin
                cur_length   = b;
                running_sum  = cur_id ^ b;
                payload_seen = '0;
                phase        = (b == 8'd0) ? RX_CHECK_BYTE : RX_PAYLOAD;
            end
            RX_PAYLOAD:
            begin
                running_sum = running_sum ^ b;
                owe_result(b, 1'b0, 1'b0);
                payload_seen = payload_seen + 8'd1;
                if (payload_seen == cur_length)
                    phase = RX_CHECK_BYTE;
            end
            default:
            begin
                owe_result(b, 1'b1, b == running_sum);
                phase = RX_WAIT_FLAG;
            end
        endcase
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(frame_result_t got);
        frame_result_t want;
        if (owed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual id 0x%0h data 0x%0h index 0x%0h",
                     $time, got.frame_id, got.data_byte, got.byte_index);
            mismatches++;
            return;
        end
        want = owed_results.pop_front();
        compare_field("frame_id", want.frame_id, got.frame_id);
        compare_field("frame_length", want.frame_length, got.frame_length);
        compare_field("data_byte", want.data_byte, got.data_byte);
        compare_field("byte_index", want.byte_index, got.byte_index);
        compare_field("is_end", 8'(want.is_end), 8'(got.is_end));
        compare_field("checksum_good", 8'(want.checksum_good), 8'(got.checksum_good));
    endfunction
endclass

module escaped_frame_receiver_tb;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    efr_pkg::byte_t  line_byte;
    logic            out_valid;
    logic            out_stall;
    efr_pkg::byte_t  frame_id;
    efr_pkg::byte_t  frame_length;
    efr_pkg::byte_t  data_byte;
    efr_pkg::byte_t  byte_index;
    logic            is_end;
    logic            checksum_good;

    deframe_scoreboard deframe_sb;

    // Line bytes of frames and of the directed sequence; noise bytes are not counted.
    int unsigned line_items = 0;

    // Sender burst bookkeeping: items left in the current burst.
    int unsigned burst_left = 0;

    escaped_frame_receiver u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .line_byte     (line_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_id      (frame_id),
        .frame_length  (frame_length),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .is_end        (is_end),
        .checksum_good (checksum_good)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Line side
    // ------------------------------------------------------------------------

    // Offers one line byte and holds it until the receiver takes it. Every
    // call starts and ends at a falling edge. The sender runs in bursts; when
    // a burst is used up it may drop valid before the next one, so gaps land
    // on every phase of a frame.
    task automatic send_byte(input efr_pkg::byte_t value, input bit counted);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        line_byte <= value;
        // The byte stays on the line, unchanged, for as long as it is stalled.
        do
            @(posedge clk);
        while (in_stall);
        deframe_sb.note_line_byte(value);
        if (counted)
            line_items++;
        @(negedge clk);
    endtask

    // Sends one logical frame byte, stuffing it where the line demands it.
    // Flag and escape values must always be escaped. Other values are
    // sometimes escaped too, unless the escaped form would itself look like
    // a flag or an escape marker. Now and then the escape marker is doubled,
    // which the receiver must treat as a single escape.
    task automatic send_field(input efr_pkg::byte_t value);
        efr_pkg::byte_t swapped;
        swapped = value ^ efr_pkg::ESCAPE_XOR;
        if (value == efr_pkg::FLAG_BYTE || value == efr_pkg::ESCAPE_BYTE ||
            ($urandom_range(0, 9) == 0 && swapped != efr_pkg::FLAG_BYTE &&
             swapped != efr_pkg::ESCAPE_BYTE)) begin
            if ($urandom_range(0, 7) == 0)
                send_byte(efr_pkg::ESCAPE_BYTE, 1'b1);
            send_byte(efr_pkg::ESCAPE_BYTE, 1'b1);
            send_byte(swapped, 1'b1);
        end
        else
            send_byte(value, 1'b1);
    endtask

    // Random byte that leans toward the values the stuffing cares about.
    function automatic efr_pkg::byte_t pick_byte();
        if ($urandom_range(0, 5) != 0)
            return efr_pkg::byte_t'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return efr_pkg::FLAG_BYTE;
            1:       return efr_pkg::ESCAPE_BYTE;
            2:       return efr_pkg::FLAG_BYTE ^ efr_pkg::ESCAPE_XOR;
            default: return efr_pkg::ESCAPE_BYTE ^ efr_pkg::ESCAPE_XOR;
        endcase
    endfunction

    // Builds a frame with random content and sends it. Most frames are short
    // and carry the right checksum; a few have a bad one. A cut frame stops
    // somewhere before its checksum, so the next flag has to restart the
    // receiver from the middle of a frame. The longest frame drives the
    // byte index through its whole range.
    task automatic send_frame(input bit cut, input bit longest);
        efr_pkg::byte_t fields[$];
        efr_pkg::byte_t sum;
        efr_pkg::byte_t value;
        int unsigned    len;
        int unsigned    keep;
        if (longest)
            len = 255;
        else if ($urandom_range(0, 11) == 0)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(0, 8);
        value = pick_byte();
        fields.push_back(value);
        fields.push_back(efr_pkg::byte_t'(len));
        sum = value ^ efr_pkg::byte_t'(len);
        repeat (len) begin
            value = pick_byte();
            sum   = sum ^ value;
            fields.push_back(value);
        end
        if ($urandom_range(0, 7) == 0)
            sum = sum ^ efr_pkg::byte_t'($urandom_range(1, 255));
        fields.push_back(sum);
        keep = cut ? $urandom_range(0, fields.size() - 1) : fields.size();
        send_byte(efr_pkg::FLAG_BYTE, 1'b1);
        for (int i = 0; i < keep; i++)
            send_field(fields[i]);
    endtask

    // Line noise. A flag is never part of it, so outside a frame the receiver
    // should drop all of it; after a cut frame it lands inside the frame.
    task automatic send_noise();
        efr_pkg::byte_t value;
        repeat ($urandom_range(1, 4)) begin
            value = efr_pkg::byte_t'($urandom_range(0, 255));
            if (value == efr_pkg::FLAG_BYTE)
                value = efr_pkg::ESCAPE_BYTE;
            send_byte(value, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        // Hand-picked line bytes:
        //   an escape marker and a byte outside any frame, both ignored;
        //   a zero-length frame with id and checksum at zero;
        //   an id of all ones with escaped flag and escape payload bytes,
        //   the second behind a doubled escape marker;
        //   an escaped id, a payload of all ones and a wrong checksum;
        //   a flag arriving while an escape is pending, restarting the frame.
        efr_pkg::byte_t directed_seq[] = '{
            8'h7D, 8'h41,
            8'h7E, 8'h00, 8'h00, 8'h00,
            8'h7E, 8'hFF, 8'h02, 8'h7D, 8'h5E, 8'h7D, 8'h7D, 8'h5D, 8'hFE,
            8'h7E, 8'h7D, 8'h5D, 8'h01, 8'hFF, 8'h00,
            8'h7E, 8'h11, 8'h03, 8'h7D, 8'h7E, 8'h22, 8'h00, 8'h22
        };
        int unsigned frame_no;
        int unsigned kind;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        line_byte  = '0;
        frame_no   = 0;
        deframe_sb = new;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_seq[i])
            send_byte(directed_seq[i], 1'b1);

        // Mostly well-formed frames with random content; the rest is noise
        // and frames cut short.
        while (line_items < 950) begin
            frame_no++;
            kind = $urandom_range(0, 19);
            if (kind < 2)
                send_noise();
            else
                send_frame(kind < 5, frame_no == 12);
        end
        in_valid <= 1'b0;

        while (deframe_sb.owed_results.size() != 0)
            @(posedge clk);
        // Give a stray result time to show up.
        repeat (8) @(posedge clk);

        if (deframe_sb.mismatches == 0 && deframe_sb.owed_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // The result side stalls in phases of its own: free running, light and heavy
    // random stalls, a regular pattern, and now and then a long hold-off. The
    // hold-off lasts long enough for the receiver to fill its two registers
    // and push back on the line while the sender keeps offering items.
    initial
    begin : result_stall
        int unsigned round_no;
        int unsigned span;
        int unsigned mode;
        int unsigned period;

        out_stall = 1'b0;
        round_no  = 0;
        @(posedge rst_n);
        forever begin
            round_no++;
            span   = $urandom_range(10, 60);
            period = $urandom_range(2, 5);
            mode   = (round_no % 8 == 3) ? 4 : $urandom_range(0, 3);
            if (mode == 4)
                span = 100;
            for (int c = 0; c < span; c++) begin
                @(negedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 2) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    3:       out_stall <= (c % period == 0);
                    default: out_stall <= 1'b1;
                endcase
            end
        end
    end

    // Every result taken by the result side goes to the scoreboard.
    always @(posedge clk)
    begin : result_monitor
        frame_result_t seen;
        if (rst_n && out_valid && !out_stall) begin
            seen.frame_id      = frame_id;
            seen.frame_length  = frame_length;
            seen.data_byte     = data_byte;
            seen.byte_index    = byte_index;
            seen.is_end        = is_end;
            seen.checksum_good = checksum_good;
            deframe_sb.check_result(seen);
        end
    end

    // Run limit, far beyond the slowest legal run.
    initial
    begin : watchdog
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule
